/* design/kpi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_pkg
// shared types, codes and reset values of the k-mer position index
// ----------------------------------------------------------------------------
package kpi_pkg;

	// default storage depth and hit cap
	localparam int KPI_DATA_DEPTH = 4096;
	localparam int KPI_MAX_HITS   = 16;

	// fixed field widths
	localparam int KMER_W = 6;
	localparam int LEN_W  = 13;
	localparam int POS_W  = 13;
	localparam int PAT_W  = 64;

	// function codes
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// register indexes
	localparam logic [1:0] REG_KMER_LEN  = 2'd0;
	localparam logic [1:0] REG_ROW_LEN   = 2'd1;
	localparam logic [1:0] REG_ROW_COUNT = 2'd2;

	// register reset values
	localparam logic [KMER_W-1:0] KMER_LEN_RST  = 6'd8;
	localparam logic [LEN_W-1:0]  ROW_LEN_RST   = 13'd64;
	localparam logic [LEN_W-1:0]  ROW_COUNT_RST = 13'd64;
	localparam logic [2*LEN_W-1:0] CAP_PROD_RST = 26'd4096;

	// longest pattern in bases
	localparam logic [KMER_W-1:0] KMER_MAX = 6'd32;

	// ascii base characters
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;

	// 2-bit base codes
	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_T = 2'd1;
	localparam logic [1:0] CODE_C = 2'd2;
	localparam logic [1:0] CODE_G = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SCAN,
		ST_DRAIN
	} kpi_state_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} kpi_code_t;

	// character to base code, ok low for anything but a, t, c, g
	function automatic kpi_code_t base_code(input logic [7:0] ch);
		kpi_code_t r;
		r.ok   = 1'b1;
		r.code = CODE_A;
		unique case (ch)
			CHAR_A: r.code = CODE_A;
			CHAR_T: r.code = CODE_T;
			CHAR_C: r.code = CODE_C;
			CHAR_G: r.code = CODE_G;
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/kmer_position_index.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_position_index
// dna base store with k-mer position search over whole rows
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An add (func 0)
// stores one base; busy stays low. A build (func 1) runs the bit-serial
// divider over stored_count. A query (func 2) runs the same divider, forms
// the scan address, then reads the bases of the scanned rows (top row times
// row_len, never more than stored_count) and drains the read pipeline; the
// base memory port, one read a cycle, sets the pace of the scan. A query with
// a bad pattern length or an empty snapshot answers without the divider.
// Results appear on found/row/column/last/truncated for exactly one cycle
// with strobe high; the receiver cannot stall them, so it must take every
// strobe. Hits come highest position first.
// ----------------------------------------------------------------------------
module kmer_position_index
	import kpi_pkg::*;
#(
	parameter int DATA_DEPTH = KPI_DATA_DEPTH,
	parameter int MAX_HITS   = KPI_MAX_HITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item channel
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        base_char,
	input  wire logic [PAT_W-1:0]  pattern,
	// register write port
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [LEN_W-1:0]  wr_data,
	// result channel
	output logic                   strobe,
	output logic                   found,
	output logic [POS_W-1:0]       row,
	output logic [POS_W-1:0]       column,
	output logic                   last,
	output logic                   truncated
);

	localparam int AW = $clog2(DATA_DEPTH);
	localparam int CW = AW + 1;                    // holds DATA_DEPTH itself
	localparam int HW = $clog2(MAX_HITS + 1);
	localparam logic [HW-1:0] HIT_MAX = HW'(MAX_HITS);

	// configuration
	logic [KMER_W-1:0]  kmer_len_q;
	logic [LEN_W-1:0]   row_len_q;
	logic [LEN_W-1:0]   row_count_q;
	logic [2*LEN_W-1:0] cap_prod_q;               // row_count * row_len

	// store state
	logic [1:0]    mem [DATA_DEPTH];
	logic [CW-1:0] stored_count_q;
	logic [CW-1:0] indexed_rows_q;

	// sequencer
	kpi_state_t    state_q, state_d;
	logic          is_query_q;
	logic [CW-1:0] top_q;
	logic [AW-1:0] addr_q;
	logic [LEN_W-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [PAT_W-1:0] pat_q;
	logic [PAT_W-1:0] mask_q;
	logic [LEN_W-1:0] lim_q;                      // last start column that fits

	// read pipeline
	logic          vld_s1, vld_s2;
	logic [1:0]    rdata_s1;
	logic [LEN_W-1:0] col_s1, col_s2;
	logic [CW-1:0] row_s1, row_s2;
	logic [PAT_W-1:0] window_q;

	// hit bookkeeping: newest hit is held back until its last flag is known
	logic [HW-1:0] hits_q;
	logic [CW-1:0] pend_row_q;
	logic [LEN_W-1:0] pend_col_q;

	// result register
	logic          strobe_q;
	logic          found_q, last_q, trunc_q;
	logic [POS_W-1:0] row_o_q, col_o_q;

	// divider
	logic          div_start;
	logic          div_done;
	logic [CW-1:0] div_quot;

	// decode
	logic          accept;
	kpi_code_t     code;
	logic          add_ok;
	logic          bad_query;
	logic [CW-1:0] top_w;
	logic [CW+LEN_W-1:0] end_prod;
	logic [6:0]    mask_shift;
	logic          hit;
	logic          stop;
	logic          emit;
	logic          emit_found, emit_last, emit_trunc;
	logic [CW-1:0] emit_row;
	logic [LEN_W-1:0] emit_col;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign code   = base_code(base_char);

	// storage full at the smaller of row_count * row_len and the memory depth
	assign add_ok = code.ok
		&& (32'(stored_count_q) < 32'(cap_prod_q))
		&& (32'(stored_count_q) < 32'(DATA_DEPTH));

	// bad length or empty snapshot answers not found at once
	assign bad_query = (kmer_len_q == '0) || (kmer_len_q > KMER_MAX)
		|| ({7'd0, kmer_len_q} > row_len_q) || (indexed_rows_q == '0);

	// rows that reach past stored_count are skipped
	assign top_w      = (div_quot > indexed_rows_q) ? indexed_rows_q : div_quot;
	assign end_prod   = top_q * row_len_q;
	assign mask_shift = 7'd64 - {kmer_len_q, 1'b0};

	assign div_start = accept && (((func == FUNC_BUILD) && (row_len_q != '0))
		|| ((func == FUNC_QUERY) && !bad_query));

	kpi_div #(
		.NW (CW),
		.DW (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (stored_count_q),
		.divisor  (row_len_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// shared compare unit: masked window against the pattern
	assign hit = vld_s2 && (col_s2 <= lim_q)
		&& (((window_q ^ pat_q) & mask_q) == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (div_start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					if (is_query_q && (top_w != '0)) state_d = ST_MUL;
					else state_d = ST_IDLE;
				end
			end
			ST_MUL: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stop) state_d = ST_IDLE;
				else if (addr_q == '0) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stop || (!vld_s1 && !vld_s2)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result selection
	always_comb begin
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_row   = '0;
		emit_col   = '0;
		emit_last  = 1'b1;
		emit_trunc = 1'b0;
		stop       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// not found straight away
				if (accept && (func == FUNC_QUERY) && bad_query) emit = 1'b1;
			end
			ST_DIV: begin
				if (div_done && is_query_q && (top_w == '0)) emit = 1'b1;
			end
			ST_SCAN, ST_DRAIN: begin
				if (hit) begin
					if (hits_q == HIT_MAX) begin
						// one hit too many: close with the held hit
						emit       = 1'b1;
						emit_found = 1'b1;
						emit_row   = pend_row_q;
						emit_col   = pend_col_q;
						emit_trunc = 1'b1;
						stop       = 1'b1;
					end else if (hits_q != '0) begin
						emit       = 1'b1;
						emit_found = 1'b1;
						emit_row   = pend_row_q;
						emit_col   = pend_col_q;
						emit_last  = 1'b0;
					end
				end else if ((state_q == ST_DRAIN) && !vld_s1 && !vld_s2) begin
					// scan over
					emit = 1'b1;
					if (hits_q != '0) begin
						emit_found = 1'b1;
						emit_row   = pend_row_q;
						emit_col   = pend_col_q;
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			kmer_len_q     <= KMER_LEN_RST;
			row_len_q      <= ROW_LEN_RST;
			row_count_q    <= ROW_COUNT_RST;
			cap_prod_q     <= CAP_PROD_RST;
			stored_count_q <= '0;
			indexed_rows_q <= '0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			hits_q         <= '0;
			strobe_q       <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			vld_s1   <= (state_q == ST_SCAN) && !stop;
			vld_s2   <= vld_s1 && !stop;

			// register writes, product kept ready for the capacity check
			if (wr_en) begin
				unique case (wr_index)
					REG_KMER_LEN: kmer_len_q <= wr_data[KMER_W-1:0];
					REG_ROW_LEN: begin
						row_len_q  <= wr_data;
						cap_prod_q <= wr_data * row_count_q;
					end
					REG_ROW_COUNT: begin
						row_count_q <= wr_data;
						cap_prod_q  <= row_len_q * wr_data;
					end
					default: ;
				endcase
			end

			if (accept && (func == FUNC_ADD) && add_ok)
				stored_count_q <= stored_count_q + 1'b1;

			// zero row length snapshots nothing
			if (accept && (func == FUNC_BUILD) && (row_len_q == '0))
				indexed_rows_q <= '0;
			if ((state_q == ST_DIV) && div_done && !is_query_q)
				indexed_rows_q <= div_quot;

			if (accept) hits_q <= '0;
			else if (hit && (hits_q != HIT_MAX)) hits_q <= hits_q + 1'b1;
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		if (accept) begin
			is_query_q <= (func == FUNC_QUERY);
			mask_q     <= {PAT_W{1'b1}} >> mask_shift;
			pat_q      <= pattern & ({PAT_W{1'b1}} >> mask_shift);
			lim_q      <= LEN_W'({1'b0, row_len_q} - {8'd0, kmer_len_q} + 14'd1);
		end
		if ((state_q == ST_DIV) && div_done) top_q <= top_w;
		unique case (state_q)
			ST_MUL: begin
				// scan starts at the last base of the top row
				addr_q <= AW'(end_prod - 1'b1);
				col_q  <= row_len_q;
				row_q  <= top_q;
			end
			ST_SCAN: begin
				addr_q <= addr_q - 1'b1;
				if (col_q == LEN_W'(1)) begin
					col_q <= row_len_q;
					row_q <= row_q - 1'b1;
				end else begin
					col_q <= col_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (hit && (hits_q != HIT_MAX)) begin
			pend_row_q <= row_s2;
			pend_col_q <= col_s2;
		end
		if (emit) begin
			found_q <= emit_found;
			row_o_q <= POS_W'(emit_row);
			col_o_q <= POS_W'(emit_col);
			last_q  <= emit_last;
			trunc_q <= emit_trunc;
		end
	end

	// base memory: write on add, one read a cycle while scanning
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_ADD) && add_ok)
			mem[stored_count_q[AW-1:0]] <= code.code;
		if (state_q == ST_SCAN)
			rdata_s1 <= mem[addr_q];
	end

	// read pipeline: scanning downwards, the newest base becomes the first
	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		row_s1 <= row_q;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		if (vld_s1) window_q <= {window_q[PAT_W-3:0], rdata_s1};
	end

	assign strobe    = strobe_q;
	assign found     = found_q;
	assign row       = row_o_q;
	assign column    = col_o_q;
	assign last      = last_q;
	assign truncated = trunc_q;

endmodule
`default_nettype wire

/* design/kpi_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kpi_div #(
	parameter int NW = 13,
	parameter int DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int CNW = $clog2(NW + 1);

	logic [CNW-1:0] cnt_q;
	logic [DW-1:0]  rem_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  dsr_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic           fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* verif/kmer_position_index_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_position_index_tb
// self-checking bench: a short table of directed transactions, then phases of
// random add/build/query runs under changing row and pattern settings; every
// result is compared field by field with a software copy of the base store
// ----------------------------------------------------------------------------
module kmer_position_index_tb;
	import kpi_pkg::*;

	// func 3 has no meaning in the block
	localparam logic [1:0] FUNC_NONE = 2'd3;

	// cycles of quiet after the last result: ample for the divider and for the
	// read pipeline to drain
	localparam int SETTLE_CYCLES = 64;

	// slowest legal run: ~200 transactions, each a full 4096-base scan plus
	// divider and gaps, taken several times over
	localparam longint TIMEOUT_NS = 40_000_000;

	// one result of a query
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic             last;
		logic             truncated;
	} hit_t;

	localparam hit_t NOT_FOUND = {1'b0, 13'd0, 13'd0, 1'b1, 1'b0};

	typedef enum logic {
		STEP_ITEM,
		STEP_WRITE
	} step_kind_e;

	// one row of the directed stimulus
	typedef struct packed {
		step_kind_e       kind;
		logic [1:0]       f;
		logic [7:0]       ch;
		logic [PAT_W-1:0] pat;
		logic [1:0]       idx;
		logic [LEN_W-1:0] val;
		logic             typed;
		hit_t             want;
	} step_t;

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic             clk;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic [1:0]       func      = FUNC_ADD;
	logic [7:0]       base_char = 8'd0;
	logic [PAT_W-1:0] pattern   = '0;
	logic             wr_en     = 1'b0;
	logic [1:0]       wr_index  = REG_KMER_LEN;
	logic [LEN_W-1:0] wr_data   = '0;
	logic             busy;
	logic             strobe;
	logic             found;
	logic [POS_W-1:0] row;
	logic [POS_W-1:0] column;
	logic             last;
	logic             truncated;

	kmer_position_index u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.base_char (base_char),
		.pattern   (pattern),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.strobe    (strobe),
		.found     (found),
		.row       (row),
		.column    (column),
		.last      (last),
		.truncated (truncated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// software copy of the block: base store, counts and registers
	// ------------------------------------------------------------------------
	logic [1:0]        base_mem [0:KPI_DATA_DEPTH-1];
	int unsigned       base_total = 0;
	int unsigned       snap_rows  = 0;
	logic [KMER_W-1:0] k_len = KMER_LEN_RST;
	logic [LEN_W-1:0]  r_len = ROW_LEN_RST;
	logic [LEN_W-1:0]  r_cnt = ROW_COUNT_RST;

	// hits still to come, oldest first
	hit_t pending_hits [$];
	step_t script [$];

	int unsigned idle_pct       = 14;
	int unsigned eff_items      = 0;
	int unsigned sent_items     = 0;
	int unsigned query_count    = 0;
	int unsigned hit_count      = 0;
	int unsigned capped_count   = 0;
	int unsigned pressure_count = 0;
	int unsigned write_count    = 0;
	int unsigned err_count      = 0;

	// walk every start of every usable snapshot row, highest position first
	task automatic search_hits(input logic [PAT_W-1:0] pat);
		int unsigned top, r, c, i, pos, hits;
		bit more, same;
		hit_t h;
		if (k_len == 0 || k_len > KMER_MAX || k_len > r_len || snap_rows == 0) begin
			pending_hits.push_back(NOT_FOUND);
		end else begin
			hits = 0;
			more = 1'b0;
			// rows of the snapshot that now reach past the stored bases are skipped
			top = base_total / r_len;
			if (top > snap_rows)
				top = snap_rows;
			r = top;
			while (r > 0 && !more) begin
				c = r_len - k_len + 1;
				while (c > 0 && !more) begin
					pos = (r - 1) * r_len + c - 1;
					same = 1'b1;
					for (i = 0; i < k_len; i++)
						if (base_mem[pos + i] != pat[2*i +: 2])
							same = 1'b0;
					if (same) begin
						// one hit past the cap only raises the flag
						if (hits == KPI_MAX_HITS) begin
							more = 1'b1;
						end else begin
							h = {1'b1, r[POS_W-1:0], c[POS_W-1:0], 1'b0, 1'b0};
							pending_hits.push_back(h);
							hits++;
						end
					end
					c--;
				end
				r--;
			end
			if (hits == 0) begin
				pending_hits.push_back(NOT_FOUND);
			end else begin
				h = pending_hits.pop_back();
				h.last = 1'b1;
				h.truncated = more;
				pending_hits.push_back(h);
			end
		end
	endtask

	// state update and expected hits for one accepted transaction
	task automatic apply_item(input logic [1:0] f, input logic [7:0] ch,
			input logic [PAT_W-1:0] pat);
		int unsigned room;
		bit ok;
		logic [1:0] code;
		room = r_cnt;
		room = room * r_len;
		if (room > KPI_DATA_DEPTH)
			room = KPI_DATA_DEPTH;
		ok = 1'b1;
		code = CODE_A;
		case (ch)
			CHAR_A: code = CODE_A;
			CHAR_T: code = CODE_T;
			CHAR_C: code = CODE_C;
			CHAR_G: code = CODE_G;
			default: ok = 1'b0;
		endcase
		case (f)
			FUNC_ADD: begin
				// non-bases and adds beyond capacity leave no trace
				if (ok && base_total < room) begin
					base_mem[base_total] = code;
					base_total++;
					eff_items++;
				end
			end
			FUNC_BUILD: begin
				snap_rows = (r_len != 0) ? base_total / r_len : 0;
				eff_items++;
			end
			FUNC_QUERY: begin
				search_hits(pat);
				eff_items++;
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic step_item(input logic [1:0] f, input logic [7:0] ch,
			input logic [PAT_W-1:0] pat, input bit typed, input hit_t want);
		step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.f = f;
		s.ch = ch;
		s.pat = pat;
		s.typed = typed;
		s.want = want;
		script.push_back(s);
	endtask

	task automatic step_write(input logic [1:0] idx, input logic [LEN_W-1:0] val);
		step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.idx = idx;
		s.val = val;
		script.push_back(s);
	endtask

	function automatic hit_t sole_hit(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
		return {1'b1, r, c, 1'b1, 1'b0};
	endfunction

	// bases with a lean towards a so that hits pile up past the cap
	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
			0, 1, 2, 3: return CHAR_A;
			4, 5:       return CHAR_T;
			6, 7:       return CHAR_C;
			default:    return CHAR_G;
		endcase
	endfunction

	// mostly a slice of a stored row, so that queries hit; spare bits random
	function automatic logic [PAT_W-1:0] pattern_from_store();
		logic [PAT_W-1:0] p;
		int unsigned rows, pos, i;
		p = {$urandom, $urandom};
		rows = (r_len != 0) ? base_total / r_len : 0;
		if (k_len >= 1 && k_len <= KMER_MAX && k_len <= r_len && rows != 0 &&
				$urandom_range(99) < 75) begin
			pos = $urandom_range(rows - 1, 0) * r_len + $urandom_range(r_len - k_len, 0);
			for (i = 0; i < k_len; i++)
				p[2*i +: 2] = base_mem[pos + i];
		end
		return p;
	endfunction

	// one transaction: hold start until busy is low at an edge, then maybe idle
	task automatic send_item(input logic [1:0] f, input logic [7:0] ch,
			input logic [PAT_W-1:0] pat, input bit typed, input hit_t want);
		int unsigned gap;
		start <= 1'b1;
		func <= f;
		base_char <= ch;
		pattern <= pat;
		wr_en <= 1'b0;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sent_items++;
		if (f == FUNC_QUERY)
			query_count++;
		// typed rows are all queries, so the store is left alone
		if (typed)
			pending_hits.push_back(want);
		else
			apply_item(f, ch, pat);
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(12, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// registers change only with nothing in flight
	task automatic quiesce();
		start <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender holds off until every pending hit is out
	task automatic drain_hits();
		if (pending_hits.size() != 0) begin
			start <= 1'b0;
			while (pending_hits.size() != 0)
				@(posedge clk);
			pressure_count++;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_KMER_LEN:  k_len = val[KMER_W-1:0];
			REG_ROW_LEN:   r_len = val;
			REG_ROW_COUNT: r_cnt = val;
			default: ;
		endcase
		write_count++;
	endtask

	// ------------------------------------------------------------------------
	// result checker: every strobe must match the oldest pending hit
	// ------------------------------------------------------------------------
	hit_t mon_want;

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (found === 1'b1)
				hit_count++;
			if (truncated === 1'b1)
				capped_count++;
			if (pending_hits.size() == 0) begin
				$error("result with nothing pending: row %0d column %0d", row, column);
				err_count++;
			end else begin
				mon_want = pending_hits.pop_front();
				if (found !== mon_want.found) begin
					$error("found: expected %0d, got %0d", mon_want.found, found);
					err_count++;
				end
				if (row !== mon_want.row) begin
					$error("row: expected %0d, got %0d", mon_want.row, row);
					err_count++;
				end
				if (column !== mon_want.column) begin
					$error("column: expected %0d, got %0d", mon_want.column, column);
					err_count++;
				end
				if (last !== mon_want.last) begin
					$error("last: expected %0d, got %0d", mon_want.last, last);
					err_count++;
				end
				if (truncated !== mon_want.truncated) begin
					$error("truncated: expected %0d, got %0d", mon_want.truncated, truncated);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int i, ph;
		int unsigned n, q, phase_base;
		bit in_writes;
		step_t cur;
		logic [LEN_W-1:0] pk, pl, pc;

		// directed table
		// empty snapshot straight after reset
		step_item(FUNC_QUERY, 8'hFF, '1, 1'b1, NOT_FOUND);
		// four-base store: one row of four
		step_write(REG_KMER_LEN, 13'd4);
		step_write(REG_ROW_LEN, 13'd4);
		step_write(REG_ROW_COUNT, 13'd1);
		step_item(FUNC_ADD, CHAR_A, '0, 1'b0, NOT_FOUND);
		// not a base, ignored
		step_item(FUNC_ADD, 8'hFF, '1, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_C, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_G, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_T, '0, 1'b0, NOT_FOUND);
		// storage full, dropped
		step_item(FUNC_ADD, CHAR_A, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, 8'h00, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_BUILD, 8'h00, '0, 1'b0, NOT_FOUND);
		// whole row matches; spare pattern bits set
		step_item(FUNC_QUERY, 8'h00, {56'hFF_FFFF_FFFF_FFFF, CODE_T, CODE_G, CODE_C, CODE_A},
			1'b1, sole_hit(13'd1, 13'd1));
		step_item(FUNC_QUERY, 8'h00, '0, 1'b1, NOT_FOUND);
		// pattern lengths that are out of range
		step_write(REG_KMER_LEN, 13'd0);
		step_item(FUNC_QUERY, 8'h00, '1, 1'b1, NOT_FOUND);
		step_write(REG_KMER_LEN, 13'd33);
		step_item(FUNC_QUERY, 8'h00, '1, 1'b1, NOT_FOUND);
		step_write(REG_KMER_LEN, 13'd5);
		step_item(FUNC_QUERY, 8'h00, '1, 1'b1, NOT_FOUND);
		step_write(REG_KMER_LEN, 13'd63);
		step_item(FUNC_QUERY, 8'h00, '1, 1'b1, NOT_FOUND);
		// zero row length gives an empty snapshot
		step_write(REG_KMER_LEN, 13'd1);
		step_write(REG_ROW_LEN, 13'd0);
		step_item(FUNC_BUILD, 8'hFF, '1, 1'b0, NOT_FOUND);
		step_item(FUNC_QUERY, 8'h00, {{62{1'b1}}, CODE_T}, 1'b1, NOT_FOUND);
		step_write(REG_ROW_LEN, 13'd4);
		step_item(FUNC_QUERY, 8'h00, {{62{1'b1}}, CODE_T}, 1'b1, NOT_FOUND);
		step_item(FUNC_BUILD, 8'h00, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_QUERY, 8'h00, {{62{1'b1}}, CODE_T}, 1'b1, sole_hit(13'd1, 13'd4));
		// one base per row, full depth of rows
		step_write(REG_ROW_LEN, 13'd1);
		step_write(REG_ROW_COUNT, 13'd4096);
		step_item(FUNC_ADD, CHAR_G, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_G, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_A, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_ADD, CHAR_G, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_BUILD, 8'h00, '0, 1'b0, NOT_FOUND);
		step_item(FUNC_QUERY, 8'h00, {{62{1'b0}}, CODE_G}, 1'b0, NOT_FOUND);
		// row length changed after the build
		step_write(REG_ROW_LEN, 13'd2);
		step_item(FUNC_QUERY, 8'h00, {{62{1'b0}}, CODE_G}, 1'b0, NOT_FOUND);
		// unused function code, no result
		step_item(FUNC_NONE, 8'hFF, '1, 1'b0, NOT_FOUND);

		// single reset at the start of the run
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_writes = 1'b0;
		for (i = 0; i < script.size(); i++) begin
			cur = script[i];
			if (cur.kind == STEP_WRITE) begin
				if (!in_writes)
					quiesce();
				in_writes = 1'b1;
				write_reg(cur.idx, cur.val);
			end else begin
				in_writes = 1'b0;
				send_item(cur.f, cur.ch, cur.pat, cur.typed, cur.want);
			end
		end

		// random phases, one register setting each
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin pk = 13'd4;    pl = 13'd16;   pc = 13'd64;   end
				1: begin pk = 13'd1;    pl = 13'd8;    pc = 13'd4096; end
				// upper data bits fall away, leaving the longest pattern
				2: begin pk = 13'h1FE0; pl = 13'd32;   pc = 13'd8;    end
				// longest row, single row
				3: begin pk = 13'd3;    pl = 13'd4096; pc = 13'd1;    end
				4: begin pk = 13'd6;    pl = 13'd12;   pc = 13'd4096; end
				// capacity already below the stored count
				default: begin pk = 13'd2; pl = 13'd3; pc = 13'd2; end
			endcase
			quiesce();
			write_reg(REG_KMER_LEN, pk);
			write_reg(REG_ROW_LEN, pl);
			write_reg(REG_ROW_COUNT, pc);
			// sender idling: light, then heavy, then none
			idle_pct = (ph < 2) ? 14 : (ph < 4) ? 81 : 0;
			phase_base = eff_items;
			while (eff_items - phase_base < 23) begin
				if ($urandom_range(99) < 10) begin
					// noise: stray characters and the unused code
					if ($urandom_range(1) == 1)
						send_item(FUNC_ADD, $urandom_range(255), {$urandom, $urandom},
							1'b0, NOT_FOUND);
					else
						send_item(FUNC_NONE, $urandom_range(255), {$urandom, $urandom},
							1'b0, NOT_FOUND);
				end else begin
					// a burst of bases, usually a build, then a few queries
					n = $urandom_range(10, 2);
					repeat (n)
						send_item(FUNC_ADD, pick_char(), {$urandom, $urandom}, 1'b0, NOT_FOUND);
					if ($urandom_range(99) < 80)
						send_item(FUNC_BUILD, $urandom_range(255), {$urandom, $urandom},
							1'b0, NOT_FOUND);
					q = $urandom_range(3, 1);
					repeat (q) begin
						if (pressure_count == 0 || $urandom_range(99) < 8)
							drain_hits();
						send_item(FUNC_QUERY, $urandom_range(255), pattern_from_store(),
							1'b0, NOT_FOUND);
					end
				end
			end
		end

		// wait for the last hits and let the block settle
		quiesce();

		$display("covered %0d transactions, %0d queries, %0d register writes, %0d bases held",
			sent_items, query_count, write_count, base_total);
		$display("checked %0d hits and %0d capped queries, %0d sender hold-offs",
			hit_count, capped_count, pressure_count);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#TIMEOUT_NS;
		$display("FAILURE");
		$finish;
	end

endmodule
